FILE: design/ytr_pkg.sv
// ----------------------------------------------------------------------------
// ytr_pkg
// Shared types, constants and a helper function for the YUYV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ytr_pkg;

	localparam int COEF_FRAC_BITS_DEF = 10;
	localparam int COORD_BITS_DEF     = 12;

	localparam int COEF_W     = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int SIZE_W     = 12;
	localparam int ORIGIN_W   = 11;
	localparam int CNT_W      = 11;
	localparam int CSUM_W     = 12;
	localparam int PROD_W     = 22;
	localparam int LUMA_W     = 8;
	localparam int COLOR_W    = 24;

	localparam logic [7:0] CHAN_MAX  = 8'd255;
	localparam logic [7:0] SCALE_NUM = 8'd220;

	localparam logic [COEF_W-1:0]   RST_COEF_RV = 12'd1404;
	localparam logic [COEF_W-1:0]   RST_COEF_GV = 12'd715;
	localparam logic [COEF_W-1:0]   RST_COEF_GU = 12'd346;
	localparam logic [COEF_W-1:0]   RST_COEF_BU = 12'd1774;
	localparam logic [SIZE_W-1:0]   RST_LINE_W  = 12'd800;
	localparam logic [SIZE_W-1:0]   RST_FRAME_H = 12'd600;
	localparam logic [ORIGIN_W-1:0] RST_ORIG_X  = 11'd20;
	localparam logic [ORIGIN_W-1:0] RST_ORIG_Y  = 11'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_RV  = 3'd0,
		REG_COEF_GV  = 3'd1,
		REG_COEF_GU  = 3'd2,
		REG_COEF_BU  = 3'd3,
		REG_LINE_W   = 3'd4,
		REG_FRAME_H  = 3'd5,
		REG_ORIGIN_X = 3'd6,
		REG_ORIGIN_Y = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] red;
		logic signed [PROD_W-1:0] green;
		logic signed [PROD_W-1:0] blue;
	} chroma_terms_t;

	typedef struct packed {
		logic [CSUM_W-1:0] x0;
		logic [CSUM_W-1:0] y0;
		logic [CSUM_W-1:0] x1;
		logic [CSUM_W-1:0] y1;
	} coord_pair_t;

	function automatic logic [7:0] sat_scale(input logic signed [PROD_W:0] c);
		logic [7:0]  cl;
		logic [15:0] prod;
		if (c < 0) begin
			cl = 8'd0;
		end else if (c > $signed({{(PROD_W-7){1'b0}}, CHAN_MAX})) begin
			cl = CHAN_MAX;
		end else begin
			cl = c[7:0];
		end
		prod = 16'(cl) * 16'(SCALE_NUM);
		return prod[15:8];
	endfunction

endpackage

`default_nettype wire

FILE: design/ytr_lane.sv
// ----------------------------------------------------------------------------
// ytr_lane
// One pixel lane: adds the shared chroma terms to its luma sample, then
// clamps and scales each channel into a packed RGB888 word.
// ----------------------------------------------------------------------------
`default_nettype none

module ytr_lane #(
	parameter int COEF_FRAC_BITS = ytr_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic [ytr_pkg::LUMA_W-1:0]  luma,
	input  wire ytr_pkg::chroma_terms_t      terms,
	output logic      [ytr_pkg::COLOR_W-1:0] color
);

	localparam int PW = ytr_pkg::PROD_W;

	logic signed [PW-1:0] sh_r, sh_g, sh_b;
	logic signed [PW:0]   luma_ext;
	logic signed [PW:0]   sum_r, sum_g, sum_b;

	assign sh_r = terms.red   >>> COEF_FRAC_BITS;
	assign sh_g = terms.green >>> COEF_FRAC_BITS;
	assign sh_b = terms.blue  >>> COEF_FRAC_BITS;

	assign luma_ext = $signed({{(PW+1-ytr_pkg::LUMA_W){1'b0}}, luma});

	assign sum_r = luma_ext + (PW+1)'(sh_r);
	assign sum_g = luma_ext + (PW+1)'(sh_g);
	assign sum_b = luma_ext + (PW+1)'(sh_b);

	assign color = {ytr_pkg::sat_scale(sum_r), ytr_pkg::sat_scale(sum_g),
		ytr_pkg::sat_scale(sum_b)};

endmodule

`default_nettype wire

FILE: design/ytr_coord.sv
// ----------------------------------------------------------------------------
// ytr_coord
// Column and row counters that place the two pixels of each item on screen.
// ----------------------------------------------------------------------------
`default_nettype none

module ytr_coord (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic                           frame_start,
	input  wire logic [ytr_pkg::SIZE_W-1:0]     line_width,
	input  wire logic [ytr_pkg::SIZE_W-1:0]     frame_height,
	input  wire logic [ytr_pkg::ORIGIN_W-1:0]   origin_x,
	input  wire logic [ytr_pkg::ORIGIN_W-1:0]   origin_y,
	output ytr_pkg::coord_pair_t                coords
);

	localparam int CW = ytr_pkg::CNT_W;

	logic [CW-1:0] col_q, row_q;
	logic [CW-1:0] col0, row0, col1, row1, col2, row2;

	function automatic logic [2*CW-1:0] advance(input logic [CW-1:0] col,
		input logic [CW-1:0] row, input logic [ytr_pkg::SIZE_W-1:0] lw,
		input logic [ytr_pkg::SIZE_W-1:0] fh);
		logic [CW:0] nc;
		logic [CW:0] nr;
		logic [CW-1:0] oc;
		logic [CW-1:0] orow;
		nc   = {1'b0, col} + (CW+1)'(1);
		nr   = {1'b0, row} + (CW+1)'(1);
		oc   = nc[CW-1:0];
		orow = row;
		if (nc[CW] || (ytr_pkg::SIZE_W'(nc) >= lw)) begin
			oc = '0;
			if (nr[CW] || (ytr_pkg::SIZE_W'(nr) >= fh)) begin
				orow = '0;
			end else begin
				orow = nr[CW-1:0];
			end
		end
		return {oc, orow};
	endfunction

	always_comb begin
		col0 = frame_start ? '0 : col_q;
		row0 = frame_start ? '0 : row_q;
		{col1, row1} = advance(col0, row0, line_width, frame_height);
		{col2, row2} = advance(col1, row1, line_width, frame_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col2;
			row_q <= row2;
		end
	end

	assign coords.x0 = {1'b0, origin_x} + {1'b0, col0};
	assign coords.y0 = {1'b0, origin_y} + {1'b0, row0};
	assign coords.x1 = {1'b0, origin_x} + {1'b0, col1};
	assign coords.y1 = {1'b0, origin_y} + {1'b0, row1};

endmodule

`default_nettype wire

FILE: design/yuyv_to_rgb_pixel_convert_top.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_pixel_convert_top
// Converts one YUYV group per item into two RGB888 pixels with coordinates.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_ready    | luma_first chroma_u luma_second chroma_v
//          |                        | frame_start
//  out     | out_valid / out_ready  | color_first x_first y_first
//          |                        | color_second x_second y_second
//  cfg     | cfg_wen                | cfg_idx cfg_data
//
// One item per cycle sustained while out_ready stays high. The first stage
// registers the chroma products and coordinates, the second is the lane
// output register that drives the result. The coordinate counters update in
// the cycle of the accept. Reset clears the counters and stage valids and
// loads the default registers. A stalled result holds; in_ready drops only
// when both stages are full.
`default_nettype none

module yuyv_to_rgb_pixel_convert_top #(
	parameter int COEF_FRAC_BITS = ytr_pkg::COEF_FRAC_BITS_DEF,
	parameter int COORD_BITS     = ytr_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [ytr_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [ytr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [ytr_pkg::LUMA_W-1:0]        luma_first,
	input  wire logic [7:0]                        chroma_u,
	input  wire logic [ytr_pkg::LUMA_W-1:0]        luma_second,
	input  wire logic [7:0]                        chroma_v,
	input  wire logic                              frame_start,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [ytr_pkg::COLOR_W-1:0]       color_first,
	output logic      [COORD_BITS-1:0]             x_first,
	output logic      [COORD_BITS-1:0]             y_first,
	output logic      [ytr_pkg::COLOR_W-1:0]       color_second,
	output logic      [COORD_BITS-1:0]             x_second,
	output logic      [COORD_BITS-1:0]             y_second
);

	localparam int PW = ytr_pkg::PROD_W;

	logic [ytr_pkg::COEF_W-1:0]   coef_rv_q, coef_gv_q, coef_gu_q, coef_bu_q;
	logic [ytr_pkg::SIZE_W-1:0]   line_width_q, frame_height_q;
	logic [ytr_pkg::ORIGIN_W-1:0] origin_x_q, origin_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_rv_q      <= ytr_pkg::RST_COEF_RV;
			coef_gv_q      <= ytr_pkg::RST_COEF_GV;
			coef_gu_q      <= ytr_pkg::RST_COEF_GU;
			coef_bu_q      <= ytr_pkg::RST_COEF_BU;
			line_width_q   <= ytr_pkg::RST_LINE_W;
			frame_height_q <= ytr_pkg::RST_FRAME_H;
			origin_x_q     <= ytr_pkg::RST_ORIG_X;
			origin_y_q     <= ytr_pkg::RST_ORIG_Y;
		end else if (cfg_wen) begin
			unique case (ytr_pkg::cfg_reg_t'(cfg_idx))
				ytr_pkg::REG_COEF_RV:  coef_rv_q      <= cfg_data;
				ytr_pkg::REG_COEF_GV:  coef_gv_q      <= cfg_data;
				ytr_pkg::REG_COEF_GU:  coef_gu_q      <= cfg_data;
				ytr_pkg::REG_COEF_BU:  coef_bu_q      <= cfg_data;
				ytr_pkg::REG_LINE_W:   line_width_q   <= cfg_data;
				ytr_pkg::REG_FRAME_H:  frame_height_q <= cfg_data;
				ytr_pkg::REG_ORIGIN_X: origin_x_q     <= cfg_data[ytr_pkg::ORIGIN_W-1:0];
				ytr_pkg::REG_ORIGIN_Y: origin_y_q     <= cfg_data[ytr_pkg::ORIGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	logic s1_valid_q, s2_valid_q;
	logic adv_s2;
	logic accept;

	assign adv_s2   = !s2_valid_q || out_ready;
	assign in_ready = !s1_valid_q || adv_s2;
	assign accept   = in_valid && in_ready;

	// Chroma products, shared by both lanes.
	logic signed [8:0]    du, dv;
	logic signed [PW-1:0] du_w, dv_w, crv_w, cgv_w, cgu_w, cbu_w;
	ytr_pkg::chroma_terms_t terms;

	assign du    = $signed({1'b0, chroma_u}) - 9'sd128;
	assign dv    = $signed({1'b0, chroma_v}) - 9'sd128;
	assign du_w  = PW'(du);
	assign dv_w  = PW'(dv);
	assign crv_w = $signed(PW'(coef_rv_q));
	assign cgv_w = $signed(PW'(coef_gv_q));
	assign cgu_w = $signed(PW'(coef_gu_q));
	assign cbu_w = $signed(PW'(coef_bu_q));

	assign terms.red   = crv_w * dv_w;
	assign terms.green = -(cgv_w * dv_w) - (cgu_w * du_w);
	assign terms.blue  = cbu_w * du_w;

	ytr_pkg::coord_pair_t coords;

	ytr_coord u_coord (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.frame_start  (frame_start),
		.line_width   (line_width_q),
		.frame_height (frame_height_q),
		.origin_x     (origin_x_q),
		.origin_y     (origin_y_q),
		.coords       (coords)
	);

	ytr_pkg::chroma_terms_t         terms_s1;
	ytr_pkg::coord_pair_t           coords_s1;
	logic [ytr_pkg::LUMA_W-1:0]     luma0_s1, luma1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			terms_s1  <= terms;
			coords_s1 <= coords;
			luma0_s1  <= luma_first;
			luma1_s1  <= luma_second;
		end
	end

	logic [ytr_pkg::COLOR_W-1:0] color0, color1;

	ytr_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane0 (
		.luma  (luma0_s1),
		.terms (terms_s1),
		.color (color0)
	);

	ytr_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane1 (
		.luma  (luma1_s1),
		.terms (terms_s1),
		.color (color1)
	);

	// Merge both lanes into the output register.
	logic [ytr_pkg::COLOR_W-1:0] color0_s2, color1_s2;
	logic [COORD_BITS-1:0]       x0_s2, y0_s2, x1_s2, y1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (adv_s2) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && s1_valid_q) begin
			color0_s2 <= color0;
			color1_s2 <= color1;
			x0_s2     <= COORD_BITS'(coords_s1.x0);
			y0_s2     <= COORD_BITS'(coords_s1.y0);
			x1_s2     <= COORD_BITS'(coords_s1.x1);
			y1_s2     <= COORD_BITS'(coords_s1.y1);
		end
	end

	assign out_valid    = s2_valid_q;
	assign color_first  = color0_s2;
	assign x_first      = x0_s2;
	assign y_first      = y0_s2;
	assign color_second = color1_s2;
	assign x_second     = x1_s2;
	assign y_second     = y1_s2;

endmodule

`default_nettype wire

FILE: design/ytr_chk.sv
// ----------------------------------------------------------------------------
// ytr_chk
// Port-level checks for the YUYV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ytr_chk #(
	parameter int COORD_BITS = ytr_pkg::COORD_BITS_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [ytr_pkg::COLOR_W-1:0]    color_first,
	input wire logic [COORD_BITS-1:0]          x_first,
	input wire logic [COORD_BITS-1:0]          y_first,
	input wire logic [ytr_pkg::COLOR_W-1:0]    color_second,
	input wire logic [COORD_BITS-1:0]          x_second,
	input wire logic [COORD_BITS-1:0]          y_second
);

	localparam logic [7:0] SCALED_MAX = 8'd219;

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(color_first)
			&& $stable(color_second) && $stable(x_first) && $stable(y_first)
			&& $stable(x_second) && $stable(y_second))
		else $error("result changed while stalled");

	// A new result shows up only after an item was taken.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching item");

	// The 220/256 scale keeps every channel at or below 219.
	a_scaled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> color_first[23:16] <= SCALED_MAX && color_first[15:8] <= SCALED_MAX
			&& color_first[7:0] <= SCALED_MAX && color_second[23:16] <= SCALED_MAX
			&& color_second[15:8] <= SCALED_MAX && color_second[7:0] <= SCALED_MAX)
		else $error("channel above scaled maximum");

	// Reset empties the output stage.
	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind yuyv_to_rgb_pixel_convert_top ytr_chk #(.COORD_BITS(COORD_BITS)) u_ytr_chk (.*);

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// YUYV to RGB pixel pair converter testbench
// Streams YUYV groups through the converter under a range of register
// settings and random idling on both sides. Every pixel pair it returns is
// compared field by field with the pair that a local model of the color math
// and the column and row counters predicts.
// ----------------------------------------------------------------------------

module testbench;

	localparam int COORD_W        = ytr_pkg::COORD_BITS_DEF;
	localparam int FRAC           = ytr_pkg::COEF_FRAC_BITS_DEF;
	localparam int CHROMA_ZERO    = 128;
	localparam int CNT_LIMIT      = (1 << ytr_pkg::CNT_W) - 1;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;

	typedef struct packed {
		bit [ytr_pkg::LUMA_W-1:0] luma_first;
		bit [7:0]                 chroma_u;
		bit [ytr_pkg::LUMA_W-1:0] luma_second;
		bit [7:0]                 chroma_v;
		bit                       frame_start;
	} yuyv_group_t;

	typedef struct packed {
		bit [ytr_pkg::COLOR_W-1:0] color_first;
		bit [COORD_W-1:0]          x_first;
		bit [COORD_W-1:0]          y_first;
		bit [ytr_pkg::COLOR_W-1:0] color_second;
		bit [COORD_W-1:0]          x_second;
		bit [COORD_W-1:0]          y_second;
	} rgb_pair_t;

	class rgb_pair_scoreboard;
		bit [ytr_pkg::COEF_W-1:0]   coef_rv, coef_gv, coef_gu, coef_bu;
		bit [ytr_pkg::SIZE_W-1:0]   line_w, frame_h;
		bit [ytr_pkg::ORIGIN_W-1:0] org_x, org_y;
		bit [ytr_pkg::CNT_W-1:0]    col, row;
		rgb_pair_t                  pending_pairs[$];
		int                         mismatches;
		int                         groups_seen;
		int                         pairs_checked;

		function new();
			coef_rv = ytr_pkg::RST_COEF_RV;
			coef_gv = ytr_pkg::RST_COEF_GV;
			coef_gu = ytr_pkg::RST_COEF_GU;
			coef_bu = ytr_pkg::RST_COEF_BU;
			line_w  = ytr_pkg::RST_LINE_W;
			frame_h = ytr_pkg::RST_FRAME_H;
			org_x   = ytr_pkg::RST_ORIG_X;
			org_y   = ytr_pkg::RST_ORIG_Y;
			col     = '0;
			row     = '0;
		endfunction

		function void write_reg(ytr_pkg::cfg_reg_t idx, bit [ytr_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ytr_pkg::REG_COEF_RV:  coef_rv = data;
				ytr_pkg::REG_COEF_GV:  coef_gv = data;
				ytr_pkg::REG_COEF_GU:  coef_gu = data;
				ytr_pkg::REG_COEF_BU:  coef_bu = data;
				ytr_pkg::REG_LINE_W:   line_w  = data;
				ytr_pkg::REG_FRAME_H:  frame_h = data;
				ytr_pkg::REG_ORIGIN_X: org_x   = data[ytr_pkg::ORIGIN_W-1:0];
				ytr_pkg::REG_ORIGIN_Y: org_y   = data[ytr_pkg::ORIGIN_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [7:0] scale_channel(int c);
			int k;
			k = (c < 0) ? 0 :
				((c > int'(ytr_pkg::CHAN_MAX)) ? int'(ytr_pkg::CHAN_MAX) : c);
			return 8'((k * int'(ytr_pkg::SCALE_NUM)) >> 8);
		endfunction

		// Arithmetic right shift of a signed int floors toward minus infinity.
		function bit [ytr_pkg::COLOR_W-1:0] pixel_color(bit [ytr_pkg::LUMA_W-1:0] luma,
			int du, int dv);
			int r, g, b;
			r = int'(luma) + ((int'(coef_rv) * dv) >>> FRAC);
			g = int'(luma) + ((-int'(coef_gv) * dv - int'(coef_gu) * du) >>> FRAC);
			b = int'(luma) + ((int'(coef_bu) * du) >>> FRAC);
			return {scale_channel(r), scale_channel(g), scale_channel(b)};
		endfunction

		function void step_counters();
			int nc, nr;
			nc = int'(col) + 1;
			nr = int'(row) + 1;
			if (nc >= int'(line_w) || nc > CNT_LIMIT) begin
				col = '0;
				row = (nr >= int'(frame_h) || nr > CNT_LIMIT) ? '0 : ytr_pkg::CNT_W'(nr);
			end else begin
				col = ytr_pkg::CNT_W'(nc);
			end
		endfunction

		function void note_group(yuyv_group_t grp);
			rgb_pair_t p;
			int        du, dv;
			du = int'(grp.chroma_u) - CHROMA_ZERO;
			dv = int'(grp.chroma_v) - CHROMA_ZERO;
			if (grp.frame_start) begin
				col = '0;
				row = '0;
			end
			p.color_first = pixel_color(grp.luma_first, du, dv);
			p.x_first = COORD_W'(org_x) + COORD_W'(col);
			p.y_first = COORD_W'(org_y) + COORD_W'(row);
			step_counters();
			p.color_second = pixel_color(grp.luma_second, du, dv);
			p.x_second = COORD_W'(org_x) + COORD_W'(col);
			p.y_second = COORD_W'(org_y) + COORD_W'(row);
			step_counters();
			pending_pairs.push_back(p);
			groups_seen++;
		endfunction

		function void compare_field(string name, bit [ytr_pkg::COLOR_W-1:0] want,
			bit [ytr_pkg::COLOR_W-1:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_pair(rgb_pair_t got);
			rgb_pair_t want;
			if (pending_pairs.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected pixel pair, expected none, actual %0h", $time, got);
				return;
			end
			want = pending_pairs.pop_front();
			pairs_checked++;
			compare_field("color_first", want.color_first, got.color_first);
			compare_field("x_first", ytr_pkg::COLOR_W'(want.x_first),
				ytr_pkg::COLOR_W'(got.x_first));
			compare_field("y_first", ytr_pkg::COLOR_W'(want.y_first),
				ytr_pkg::COLOR_W'(got.y_first));
			compare_field("color_second", want.color_second, got.color_second);
			compare_field("x_second", ytr_pkg::COLOR_W'(want.x_second),
				ytr_pkg::COLOR_W'(got.x_second));
			compare_field("y_second", ytr_pkg::COLOR_W'(want.y_second),
				ytr_pkg::COLOR_W'(got.y_second));
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_wen = 1'b0;
	logic [ytr_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [ytr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [ytr_pkg::LUMA_W-1:0]     luma_first = '0;
	logic [7:0]                     chroma_u = '0;
	logic [ytr_pkg::LUMA_W-1:0]     luma_second = '0;
	logic [7:0]                     chroma_v = '0;
	logic                           frame_start = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [ytr_pkg::COLOR_W-1:0]    color_first;
	logic [COORD_W-1:0]             x_first;
	logic [COORD_W-1:0]             y_first;
	logic [ytr_pkg::COLOR_W-1:0]    color_second;
	logic [COORD_W-1:0]             x_second;
	logic [COORD_W-1:0]             y_second;

	rgb_pair_scoreboard pairs;
	int send_idle_pct = 11;
	int recv_idle_pct = 46;
	int hold_gen = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_cycles = 0;
	int settings_used = 1;

	yuyv_to_rgb_pixel_convert_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.luma_first(luma_first),
		.chroma_u(chroma_u),
		.luma_second(luma_second),
		.chroma_v(chroma_v),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.color_first(color_first),
		.x_first(x_first),
		.y_first(y_first),
		.color_second(color_second),
		.x_second(x_second),
		.y_second(y_second)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_gen != hold_seen) begin
			hold_seen = hold_gen;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen)
				pairs.write_reg(ytr_pkg::cfg_reg_t'(cfg_idx), cfg_data);
			if (in_valid && in_ready)
				pairs.note_group('{luma_first, chroma_u, luma_second, chroma_v, frame_start});
			if (out_valid && out_ready)
				pairs.check_pair('{color_first, x_first, y_first,
					color_second, x_second, y_second});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_wen || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, stall_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic yuyv_group_t group_of(int y0, int u, int y1, int v, bit fs);
		yuyv_group_t g;
		g.luma_first  = ytr_pkg::LUMA_W'(y0);
		g.chroma_u    = 8'(u);
		g.luma_second = ytr_pkg::LUMA_W'(y1);
		g.chroma_v    = 8'(v);
		g.frame_start = fs;
		return g;
	endfunction

	function automatic yuyv_group_t random_group(bit fs);
		return group_of($urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), fs);
	endfunction

	task automatic send_group(yuyv_group_t g);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		luma_first  <= g.luma_first;
		chroma_u    <= g.chroma_u;
		luma_second <= g.luma_second;
		chroma_v    <= g.chroma_v;
		frame_start <= g.frame_start;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random(int count, int fs_pct);
		for (int i = 0; i < count; i++)
			send_group(random_group($urandom_range(99) < fs_pct));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pairs.pending_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(ytr_pkg::cfg_reg_t r, bit [ytr_pkg::CFG_DATA_W-1:0] d);
		cfg_wen  <= 1'b1;
		cfg_idx  <= r;
		cfg_data <= d;
		@(negedge clk);
	endtask

	task automatic program_regs(int rv, int gv, int gu, int bu, int lw, int fh, int ox, int oy);
		cfg_write(ytr_pkg::REG_COEF_RV, ytr_pkg::CFG_DATA_W'(rv));
		cfg_write(ytr_pkg::REG_COEF_GV, ytr_pkg::CFG_DATA_W'(gv));
		cfg_write(ytr_pkg::REG_COEF_GU, ytr_pkg::CFG_DATA_W'(gu));
		cfg_write(ytr_pkg::REG_COEF_BU, ytr_pkg::CFG_DATA_W'(bu));
		cfg_write(ytr_pkg::REG_LINE_W, ytr_pkg::CFG_DATA_W'(lw));
		cfg_write(ytr_pkg::REG_FRAME_H, ytr_pkg::CFG_DATA_W'(fh));
		cfg_write(ytr_pkg::REG_ORIGIN_X, ytr_pkg::CFG_DATA_W'(ox));
		cfg_write(ytr_pkg::REG_ORIGIN_Y, ytr_pkg::CFG_DATA_W'(oy));
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	initial begin
		pairs = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset weights and sizes: extremes, centered chroma and floors just off zero.
		send_group(group_of(0, 0, 0, 0, 1'b1));
		send_group(group_of(255, 255, 255, 255, 1'b0));
		send_group(group_of(0, 0, 255, 255, 1'b0));
		send_group(group_of(255, 255, 0, 0, 1'b0));
		send_group(group_of(128, 128, 128, 128, 1'b0));
		send_group(group_of(255, 0, 255, 0, 1'b0));
		send_group(group_of(0, 255, 0, 255, 1'b0));
		send_group(group_of(16, 0, 235, 255, 1'b0));
		send_group(group_of(235, 255, 16, 0, 1'b0));
		send_group(group_of(255, 128, 0, 128, 1'b1));
		send_group(group_of(1, 127, 254, 129, 1'b0));
		send_group(group_of(0, 129, 0, 127, 1'b0));

		// The output side stops for a long stretch while groups keep coming.
		hold_gen = hold_gen + 1;
		send_random(120, 3);
		drain();

		program_regs(0, 0, 0, 0, 0, 0, 0, 0);
		send_random(30, 5);
		drain();

		// Full scale weights, unit sizes and origins with the unused top bit set.
		program_regs(4095, 4095, 4095, 4095, 1, 1, 4095, 4095);
		send_random(30, 5);
		drain();

		send_idle_pct = 46;
		recv_idle_pct = 11;
		program_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), 37, 6, $urandom_range(2047), $urandom_range(2047));
		send_random(120, 2);
		drain();

		// Sizes shrink below where the counters stand.
		program_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), 3, 2, 2000, 2047);
		send_random(30, 0);
		drain();

		// Oversized sizes: the column counter runs to its top and wraps.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), 4095, 4095, $urandom_range(2047), $urandom_range(2047));
		send_group(random_group(1'b1));
		send_random(1030, 0);
		drain();

		// One pixel per row: the row counter wraps every five pixels.
		program_regs($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), 1, 5, $urandom_range(2047), $urandom_range(2047));
		send_group(random_group(1'b1));
		send_random(175, 3);
		drain();
		repeat (8) @(posedge clk);

		$display("Converted %0d YUYV groups into %0d checked pixel pairs over %0d settings,",
			pairs.groups_seen, pairs.pairs_checked, settings_used);
		$display("with zero, unit and oversized frame sizes, extreme weights and a long stall.");
		if (pairs.mismatches == 0 && pairs.pending_pairs.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d pixel pairs never arrived",
				pairs.mismatches, pairs.pending_pairs.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
